FILE: design/sm4_pkg.sv
// SM4 package: S-box, constants, round functions and shared types.
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RkIdxW    = 5;

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_MODE = 3'd4;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t x0;
    word_t x1;
    word_t x2;
    word_t x3;
  } blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t tau(input word_t v);
    tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic word_t rol(input word_t v, input int unsigned n);
    rol = (v << n) | (v >> (32 - n));
  endfunction

  function automatic word_t lin_d(input word_t v);
    lin_d = v ^ rol(v, 2) ^ rol(v, 10) ^ rol(v, 18) ^ rol(v, 24);
  endfunction

  function automatic word_t lin_k(input word_t v);
    lin_k = v ^ rol(v, 13) ^ rol(v, 23);
  endfunction

  // CK[i] byte j = (4i+j)*7 mod 256, byte 0 most significant
  function automatic word_t ck(input logic [RkIdxW-1:0] i);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    b0 = 8'({i, 2'd0} * 7);
    b1 = 8'({i, 2'd1} * 7);
    b2 = 8'({i, 2'd2} * 7);
    b3 = 8'({i, 2'd3} * 7);
    ck = {b0, b1, b2, b3};
  endfunction

endpackage

FILE: design/sm4_round.sv
// One registered SM4 round: block round or key-schedule round.
module sm4_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic                is_key_i,
  input  sm4_pkg::word_t      rk_i,
  input  sm4_pkg::blk_t       st_i,
  output logic                vld_o,
  output sm4_pkg::blk_t       st_o
);
  import sm4_pkg::*;

  word_t t;
  word_t n;
  logic  vld_r;
  blk_t  st_r;

  always_comb begin
    t = tau(st_i.x1 ^ st_i.x2 ^ st_i.x3 ^ rk_i);
    n = st_i.x0 ^ (is_key_i ? lin_k(t) : lin_d(t));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    st_r <= '{x0: st_i.x1, x1: st_i.x2, x2: st_i.x3, x3: n};
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
endmodule

FILE: design/sm4_key_sched.sv
// Round key expansion, registered when the key registers change.
module sm4_key_sched (
  input  logic            clk,
  input  logic            rst_n,
  input  sm4_pkg::blk_t   mk_i,
  input  logic            load_i,
  output sm4_pkg::word_t  rk_o [32],
  output logic            busy_o
);
  import sm4_pkg::*;

  blk_t              k_r;
  logic [RkIdxW-1:0] idx_r;
  logic              run_r;
  word_t             rk_r [NumRounds];
  word_t             n;

  always_comb begin
    n = k_r.x0 ^ lin_k(tau(k_r.x1 ^ k_r.x2 ^ k_r.x3 ^ ck(idx_r)));
  end

  // one schedule round per cycle while running, after reset or a key load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b1;
      idx_r <= '0;
      k_r   <= '{x0: FK0, x1: FK1, x2: FK2, x3: FK3};
    end else if (load_i) begin
      run_r <= 1'b1;
      idx_r <= '0;
      k_r   <= '{x0: mk_i.x0 ^ FK0, x1: mk_i.x1 ^ FK1,
                 x2: mk_i.x2 ^ FK2, x3: mk_i.x3 ^ FK3};
    end else if (run_r) begin
      k_r   <= '{x0: k_r.x1, x1: k_r.x2, x2: k_r.x3, x3: n};
      idx_r <= idx_r + 1'b1;
      if (idx_r == RkIdxW'(NumRounds - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_r && !load_i) begin
      rk_r[idx_r] <= n;
    end
  end

  assign rk_o   = rk_r;
  assign busy_o = run_r;
endmodule

FILE: design/sm4_block_cipher.sv
// SM4 block cipher top level: config registers, key schedule, 32-stage round pipeline.
//
//  channel | ports                              | handshake
//  input   | in_block_in_w0..w3                 | start & !busy
//  result  | out_block_out_w0..w3               | out_valid strobe, one cycle
//  config  | cfg_we, cfg_index, cfg_wdata       | write on cfg_we
//
// Each accepted block passes through the 32 round stages in order, one round per stage.
// Throughput: one block per cycle while busy is low; each of the 32 round stages owns a register.
// Reset and each key write start a key expansion (one round key per
// cycle from the shared schedule round); busy is high during it.
// The receiver cannot stall, so the pipeline never holds.
module sm4_block_cipher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sm4_pkg::word_t       in_block_in_w0,
  input  sm4_pkg::word_t       in_block_in_w1,
  input  sm4_pkg::word_t       in_block_in_w2,
  input  sm4_pkg::word_t       in_block_in_w3,
  output logic                 out_valid,
  output sm4_pkg::word_t       out_block_out_w0,
  output sm4_pkg::word_t       out_block_out_w1,
  output sm4_pkg::word_t       out_block_out_w2,
  output sm4_pkg::word_t       out_block_out_w3,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  sm4_pkg::word_t       cfg_wdata
);
  import sm4_pkg::*;

  blk_t  mk_r;
  logic  dec_r;
  logic  key_load;
  logic  ks_busy;
  word_t rk [NumRounds];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mk_r  <= '0;
      dec_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0: mk_r.x0 <= cfg_wdata;
        CFG_KEY1: mk_r.x1 <= cfg_wdata;
        CFG_KEY2: mk_r.x2 <= cfg_wdata;
        CFG_KEY3: mk_r.x3 <= cfg_wdata;
        CFG_MODE: dec_r   <= cfg_wdata[0];
        default:  ;
      endcase
    end
  end

  // restart expansion the cycle after a key word lands
  logic key_wr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_wr_r <= 1'b0;
    end else begin
      key_wr_r <= cfg_we && (cfg_index == CFG_KEY0 || cfg_index == CFG_KEY1 ||
                             cfg_index == CFG_KEY2 || cfg_index == CFG_KEY3);
    end
  end
  assign key_load = key_wr_r;

  sm4_key_sched u_ks (
    .clk    (clk),
    .rst_n  (rst_n),
    .mk_i   (mk_r),
    .load_i (key_load),
    .rk_o   (rk),
    .busy_o (ks_busy)
  );

  // busy also covers the cycle a key write is pending
  assign busy = ks_busy || key_load;

  logic accept;
  assign accept = start && !busy;

  // round pipeline: stage i uses rk[i], or rk[31-i] when decrypting
  logic vld [NumRounds+1];
  blk_t st  [NumRounds+1];

  assign vld[0] = accept;
  assign st[0]  = '{x0: in_block_in_w0, x1: in_block_in_w1,
                    x2: in_block_in_w2, x3: in_block_in_w3};

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    word_t rk_sel;
    assign rk_sel = dec_r ? rk[NumRounds-1-g] : rk[g];
    sm4_round u_rnd (
      .clk      (clk),
      .rst_n    (rst_n),
      .vld_i    (vld[g]),
      .is_key_i (1'b0),
      .rk_i     (rk_sel),
      .st_i     (st[g]),
      .vld_o    (vld[g+1]),
      .st_o     (st[g+1])
    );
  end

  assign out_valid        = vld[NumRounds];
  assign out_block_out_w0 = st[NumRounds].x3;
  assign out_block_out_w1 = st[NumRounds].x2;
  assign out_block_out_w2 = st[NumRounds].x1;
  assign out_block_out_w3 = st[NumRounds].x0;

  // out_valid must equal accept delayed through the acc_d shift register, one entry per round stage
  logic acc_d [NumRounds];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRounds; i++) acc_d[i] <= 1'b0;
    end else begin
      acc_d[0] <= accept;
      for (int i = 1; i < NumRounds; i++) acc_d[i] <= acc_d[i-1];
    end
  end

  a_out_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == acc_d[NumRounds-1]) else $error("result not 32 cycles after accept");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    key_load |-> busy) else $error("accept possible during key load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ks_busy |-> !vld[0]) else $error("block entered with partial round keys");

endmodule

FILE: verif/sm4_block_cipher_tb.sv
// Self-checking testbench for the SM4 block cipher: scoreboard against a local SM4 predictor.
module sm4_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sm4_pkg::*;

  localparam int unsigned LatencyCycles = 40;   // 32-stage pipeline plus margin

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  word_t in_w0 = '0, in_w1 = '0, in_w2 = '0, in_w3 = '0;
  logic  out_valid;
  word_t out_w0, out_w1, out_w2, out_w3;
  logic  cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_KEY0;
  word_t cfg_wdata = '0;

  sm4_block_cipher dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_block_in_w0(in_w0), .in_block_in_w1(in_w1),
    .in_block_in_w2(in_w2), .in_block_in_w3(in_w3),
    .out_valid(out_valid),
    .out_block_out_w0(out_w0), .out_block_out_w1(out_w1),
    .out_block_out_w2(out_w2), .out_block_out_w3(out_w3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------- predictor ----------------
  word_t key_mirror [4];
  logic  decrypt_mirror;

  function automatic word_t sub_bytes(input word_t v);
    sub_bytes = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // CK byte j of round i: (4i+j)*7 mod 256, MSB first
  function automatic word_t round_ck(input int i);
    word_t c;
    c = '0;
    for (int j = 0; j < 4; j++) c = (c << 8) | word_t'(((4 * i + j) * 7) & 8'hff);
    round_ck = c;
  endfunction

  function automatic blk_t sm4_cipher(input blk_t b);
    word_t k [4];
    word_t rk [32];
    word_t x [4];
    word_t t, n, rkey;
    k[0] = key_mirror[0] ^ 32'ha3b1bac6;
    k[1] = key_mirror[1] ^ 32'h56aa3350;
    k[2] = key_mirror[2] ^ 32'h677d9197;
    k[3] = key_mirror[3] ^ 32'hb27022dc;
    for (int i = 0; i < 32; i++) begin
      t = sub_bytes(k[1] ^ k[2] ^ k[3] ^ round_ck(i));
      n = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
      rk[i] = n;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = n;
    end
    x[0] = b.x0; x[1] = b.x1; x[2] = b.x2; x[3] = b.x3;
    for (int i = 0; i < 32; i++) begin
      rkey = decrypt_mirror ? rk[31 - i] : rk[i];
      t = sub_bytes(x[1] ^ x[2] ^ x[3] ^ rkey);
      n = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = n;
    end
    sm4_cipher = '{x0: x[3], x1: x[2], x2: x[1], x3: x[0]};
  endfunction

  // ---------------- driver ----------------
  blk_t pending_blocks [$];
  blk_t expected_blocks [$];
  int   send_idle_pct = 0;
  bit   hold_off = 1'b0;
  int   err_count = 0;

  // start stays up across back-to-back beats; predictor runs on acceptance
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_blocks.push_back(sm4_cipher('{in_w0, in_w1, in_w2, in_w3}));
      void'(pending_blocks.pop_front());
    end
    if (rst_n && !hold_off && (!start || !busy)) begin
      // next beat is the queue head (the accepted one is already popped)
      if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        blk_t nb;
        nb = pending_blocks[0];
        start <= 1'b1;
        in_w0 <= nb.x0; in_w1 <= nb.x1; in_w2 <= nb.x2; in_w3 <= nb.x3;
      end else begin
        start <= 1'b0;
      end
    end else if (hold_off && start && !busy) begin
      start <= 1'b0;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_blocks.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result beat %h %h %h %h",
                                      out_w0, out_w1, out_w2, out_w3);
      end else begin
        blk_t e;
        e = expected_blocks.pop_front();
        if (e.x0 !== out_w0 || e.x1 !== out_w1 || e.x2 !== out_w2 || e.x3 !== out_w3) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp %h %h %h %h got %h %h %h %h",
                     e.x0, e.x1, e.x2, e.x3, out_w0, out_w1, out_w2, out_w3);
        end
      end
    end
  end

  // ---------------- sequencing ----------------
  task automatic wait_drained();
    while (pending_blocks.size() != 0 || start) @(posedge clk);
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input word_t val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // mirror updates when the write lands
    case (idx)
      CFG_KEY0: key_mirror[0] = val;
      CFG_KEY1: key_mirror[1] = val;
      CFG_KEY2: key_mirror[2] = val;
      CFG_KEY3: key_mirror[3] = val;
      CFG_MODE: decrypt_mirror = val[0];
      default: ;
    endcase
  endtask

  task automatic load_key(input word_t k0, k1, k2, k3, input logic dec);
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_MODE, {31'(0), dec});
  endtask

  function automatic blk_t rand_block();
    rand_block = '{$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    key_mirror = '{default: '0};
    decrypt_mirror = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset key (all zero), encrypt: field extremes
    pending_blocks.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
    pending_blocks.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
    wait_drained();

    // standard test vector, encrypt then decrypt
    load_key(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210, 1'b0);
    pending_blocks.push_back('{32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210});
    pending_blocks.push_back('{32'h80000000, 32'h0, 32'h0, 32'h1});
    wait_drained();
    write_reg(CFG_MODE, 32'hfffffffe);   // wide value, low bit 0: still encrypt
    write_reg(CFG_MODE, 32'h00000003);   // low bit 1: decrypt
    pending_blocks.push_back('{32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246});
    pending_blocks.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
    wait_drained();

    // all-ones key, both modes
    load_key('1, '1, '1, '1, 1'b1);
    pending_blocks.push_back('{32'hffffffff, 32'h0, 32'hffffffff, 32'h0});
    wait_drained();
    write_reg(CFG_MODE, 32'h0);
    pending_blocks.push_back('{32'h0, 32'hffffffff, 32'h0, 32'hffffffff});
    wait_drained();

    // random phases with changing idle profile and keys
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 34 : (ph % 3 == 1) ? 69 : 0;
      load_key($urandom, $urandom, $urandom, $urandom, ph[0]);
      for (int i = 0; i < 100; i++) begin
        pending_blocks.push_back(rand_block());
        if (i == 50) begin
          // pause until the pipeline has fully drained
          while (pending_blocks.size() != 0 || start) @(posedge clk);
          hold_off = 1'b1;
          while (expected_blocks.size() != 0) @(posedge clk);
          hold_off = 1'b0;
        end
      end
      wait_drained();
    end

    if (err_count == 0 && expected_blocks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
